FILE: src/trpid_pkg.sv
`default_nettype none

package trpid_pkg;

    // Fixed field widths of the block.
    localparam int DATA_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int PACK_W     = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int AXIS_W     = 2;
    localparam int STEP_W     = 5;
    localparam int OPA_W      = 26;
    localparam int OPB_W      = 25;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int ACC_W      = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_P_GAINS           = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_I_GAINS           = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_D_GAINS           = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_GAINS          = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME         = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_STEP_TIME = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA      = 4'd7;

    // Axis codes used for gain selection.
    localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;

    // Last micro-step of one axis.
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd19;

    // Register file contents.
    typedef struct packed {
        logic [PACK_W-1:0] p_gains;
        logic [PACK_W-1:0] i_gains;
        logic [PACK_W-1:0] d_gains;
        logic [PACK_W-1:0] ff_gains;
        logic [22:0]       integral_limit;
        logic [23:0]       step_time;
        logic [23:0]       inverse_step_time;
        logic [15:0]       filter_alpha;
    } cfg_t;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ERR_IG,
        OP_INC_DT,
        OP_DIFF_INVDT,
        OP_ALPHA_DL,
        OP_ALPHA_DH,
        OP_PG_ERR,
        OP_INTEG_UNIT,
        OP_DG_FDL,
        OP_DG_FDH,
        OP_FF_SP
    } mac_op_t;

    // Writeback taken from the accumulator.
    typedef enum logic [2:0] {
        WB_NONE,
        WB_LOAD,
        WB_INC1,
        WB_INTEG,
        WB_DERIV,
        WB_FD,
        WB_TORQUE
    } wb_t;

    // One entry of the micro-step sequence.
    typedef struct packed {
        mac_op_t op;
        logic    clr;
        logic    sh24;
        wb_t     wb;
    } step_t;

    // Control sent to the multiply-accumulate unit.
    typedef struct packed {
        logic en;
        logic clr;
        logic sh24;
    } mac_ctl_t;

    // Micro-step sequence for one axis. A product issued in one step passes
    // the product register into the accumulator before a writeback reads it.
    function automatic step_t step_rom(input logic [STEP_W-1:0] s);
        step_t st;
        st.op   = OP_NONE;
        st.clr  = 1'b0;
        st.sh24 = 1'b0;
        st.wb   = WB_NONE;
        case (s)
            5'd0:  st.wb = WB_LOAD;
            5'd1:  begin st.op = OP_ERR_IG;     st.clr = 1'b1; end
            5'd3:  st.wb = WB_INC1;
            5'd4:  begin st.op = OP_INC_DT;     st.clr = 1'b1; end
            5'd6:  begin st.op = OP_DIFF_INVDT; st.clr = 1'b1; st.wb = WB_INTEG; end
            5'd8:  st.wb = WB_DERIV;
            5'd9:  begin st.op = OP_ALPHA_DL;   st.clr = 1'b1; end
            5'd10: begin st.op = OP_ALPHA_DH;   st.sh24 = 1'b1; end
            5'd12: st.wb = WB_FD;
            5'd13: begin st.op = OP_PG_ERR;     st.clr = 1'b1; end
            5'd14: st.op = OP_INTEG_UNIT;
            5'd15: st.op = OP_DG_FDL;
            5'd16: begin st.op = OP_DG_FDH;     st.sh24 = 1'b1; end
            5'd17: st.op = OP_FF_SP;
            5'd19: st.wb = WB_TORQUE;
            default: st.wb = WB_NONE;
        endcase
        return st;
    endfunction

    // Pick one axis gain out of a packed gain register.
    function automatic logic [GAIN_W-1:0] gain_sel(input logic [PACK_W-1:0] packed_gains,
                                                   input logic [AXIS_W-1:0] axis);
        logic [GAIN_W-1:0] g;
        case (axis)
            AXIS_ROLL:  g = packed_gains[15:0];
            AXIS_PITCH: g = packed_gains[31:16];
            AXIS_YAW:   g = packed_gains[47:32];
            default:    g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: src/trpid_if.sv
`default_nettype none

// Sample channel: setpoints and measured rates of all three axes.
interface trpid_in_if;
    import trpid_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] setpoint_roll;
    logic signed [DATA_W-1:0] setpoint_pitch;
    logic signed [DATA_W-1:0] setpoint_yaw;
    logic signed [DATA_W-1:0] measured_roll;
    logic signed [DATA_W-1:0] measured_pitch;
    logic signed [DATA_W-1:0] measured_yaw;

    modport source (
        output valid, setpoint_roll, setpoint_pitch, setpoint_yaw,
               measured_roll, measured_pitch, measured_yaw,
        input  ready
    );
    modport sink (
        input  valid, setpoint_roll, setpoint_pitch, setpoint_yaw,
               measured_roll, measured_pitch, measured_yaw,
        output ready
    );
endinterface

// Torque channel: one command per axis.
interface trpid_out_if;
    import trpid_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] torque_roll;
    logic signed [DATA_W-1:0] torque_pitch;
    logic signed [DATA_W-1:0] torque_yaw;

    modport source (
        output valid, torque_roll, torque_pitch, torque_yaw,
        input  ready
    );
    modport sink (
        input  valid, torque_roll, torque_pitch, torque_yaw,
        output ready
    );
endinterface

// Configuration write channel.
interface trpid_cfg_if;
    import trpid_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PACK_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/three_axis_rate_pid_core.sv
`default_nettype none

// Three-axis rate PID controller. Each sample transfer carries roll, pitch
// and yaw setpoints and measured rates in signed Q8.16; one torque transfer
// of three saturated Q8.16 commands follows it. Per axis the block updates
// a clamped integrator, a low-passed derivative on the measured rate and
// the torque sum through one shared 26 x 25 bit multiply-accumulate unit
// run by a 20-step sequencer per axis, after which the results of all
// axes go to the output register together. The sample channel is ready
// only while no sample is being worked on; a finished result may wait
// at the output while the next sample is taken. Axes above AXES give
// zero torque. Configuration writes go through the cfg channel, register
// i at index i; indexes past the last register are ignored.
module three_axis_rate_pid_core #(
    parameter int AXES = 3
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    trpid_in_if.sink   samples,
    trpid_out_if.source torques,
    trpid_cfg_if.sink  cfg
);
    import trpid_pkg::*;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    cfg_t     regs;
    mac_ctl_t mac_ctl;
    step_t    step;

    logic signed [OPA_W-1:0] op_a;
    logic signed [OPB_W-1:0] op_b;
    logic signed [ACC_W-1:0] acc;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic              out_valid_reg, out_valid_next;

    // Working values of the current axis.
    logic signed [24:0] err_reg, err_next;
    logic signed [24:0] diff_reg, diff_next;
    logic signed [25:0] inc1_reg, inc1_next;
    logic signed [40:0] d_reg, d_next;

    // Per-axis state and captured inputs; entry 0 is the axis in work.
    logic signed [23:0] sp_reg [AXES];
    logic signed [23:0] sp_next [AXES];
    logic signed [23:0] meas_reg [AXES];
    logic signed [23:0] meas_next [AXES];
    logic signed [23:0] integ_reg [AXES];
    logic signed [23:0] integ_next [AXES];
    logic signed [23:0] prev_reg [AXES];
    logic signed [23:0] prev_next [AXES];
    logic signed [39:0] fd_reg [AXES];
    logic signed [39:0] fd_next [AXES];
    logic signed [23:0] work_reg [AXES];
    logic signed [23:0] work_next [AXES];

    // Output register.
    logic signed [23:0] out_reg [3];
    logic signed [23:0] out_next [3];

    logic signed [23:0] in_sp [3];
    logic signed [23:0] in_meas [3];
    logic signed [23:0] final_tq [3];

    logic [GAIN_W-1:0] pg, ig, dg, ffg;

    // Rounded views of the accumulator, ties toward plus infinity.
    logic signed [ACC_W-1:0] rnd8, rnd16, rnd24;
    logic signed [27:0]      integ_sum, lim_pos, lim_neg;
    logic signed [23:0]      integ_new;
    logic signed [42:0]      r8_43, r16_43;
    logic signed [39:0]      deriv_new;
    logic signed [43:0]      fd_sum;
    logic signed [39:0]      fd_new;
    logic signed [23:0]      tq_new;

    localparam logic signed [42:0] MAX40_43 = 43'sd549755813887;
    localparam logic signed [42:0] MIN40_43 = -43'sd549755813888;
    localparam logic signed [43:0] MAX40_44 = 44'sd549755813887;
    localparam logic signed [43:0] MIN40_44 = -44'sd549755813888;
    localparam logic signed [42:0] MAX24_43 = 43'sd8388607;
    localparam logic signed [42:0] MIN24_43 = -43'sd8388608;

    trpid_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    trpid_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (acc)
    );

    // Handshake and payload ports.
    assign samples.ready        = (state_reg == ST_IDLE);
    assign torques.valid        = out_valid_reg;
    assign torques.torque_roll  = out_reg[0];
    assign torques.torque_pitch = out_reg[1];
    assign torques.torque_yaw   = out_reg[2];

    assign in_sp[0]   = samples.setpoint_roll;
    assign in_sp[1]   = samples.setpoint_pitch;
    assign in_sp[2]   = samples.setpoint_yaw;
    assign in_meas[0] = samples.measured_roll;
    assign in_meas[1] = samples.measured_pitch;
    assign in_meas[2] = samples.measured_yaw;

    // Finished torques in axis order; unused axes read as zero.
    for (genvar g = 0; g < 3; g++)
    begin : g_final
        if (g < AXES)
        begin : g_used
            assign final_tq[g] = work_reg[g];
        end
        else
        begin : g_unused
            assign final_tq[g] = '0;
        end
    end

    // Gains of the axis in work.
    assign pg  = gain_sel(regs.p_gains, axis_reg);
    assign ig  = gain_sel(regs.i_gains, axis_reg);
    assign dg  = gain_sel(regs.d_gains, axis_reg);
    assign ffg = gain_sel(regs.ff_gains, axis_reg);

    // Sequencer step and multiplier control.
    assign step        = step_rom(step_reg);
    assign mac_ctl.en  = (state_reg == ST_RUN) && (step.op != OP_NONE);
    assign mac_ctl.clr = step.clr;
    assign mac_ctl.sh24 = step.sh24;

    // Operand selection for the shared multiplier. Wide operands are split
    // into an unsigned low part of 24 bits and a signed high part.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step.op)
            OP_ERR_IG:
            begin
                op_a = {err_reg[24], err_reg};
                op_b = {9'd0, ig};
            end
            OP_INC_DT:
            begin
                op_a = inc1_reg;
                op_b = {1'b0, regs.step_time};
            end
            OP_DIFF_INVDT:
            begin
                op_a = {diff_reg[24], diff_reg};
                op_b = {1'b0, regs.inverse_step_time};
            end
            OP_ALPHA_DL:
            begin
                op_a = {2'b00, d_reg[23:0]};
                op_b = {9'd0, regs.filter_alpha};
            end
            OP_ALPHA_DH:
            begin
                op_a = {{9{d_reg[40]}}, d_reg[40:24]};
                op_b = {9'd0, regs.filter_alpha};
            end
            OP_PG_ERR:
            begin
                op_a = {err_reg[24], err_reg};
                op_b = {9'd0, pg};
            end
            OP_INTEG_UNIT:
            begin
                op_a = {{2{integ_reg[0][23]}}, integ_reg[0]};
                op_b = 25'sd65536;
            end
            OP_DG_FDL:
            begin
                op_a = {2'b00, fd_reg[0][23:0]};
                op_b = {9'd0, dg};
            end
            OP_DG_FDH:
            begin
                op_a = {{10{fd_reg[0][39]}}, fd_reg[0][39:24]};
                op_b = {9'd0, dg};
            end
            OP_FF_SP:
            begin
                op_a = {{2{sp_reg[0][23]}}, sp_reg[0]};
                op_b = {9'd0, ffg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Rounding of the accumulator.
    assign rnd8  = (acc + 64'sd128) >>> 8;
    assign rnd16 = (acc + 64'sd32768) >>> 16;
    assign rnd24 = (acc + 64'sd8388608) >>> 24;
    assign r8_43  = rnd8[42:0];
    assign r16_43 = rnd16[42:0];

    // Integrator update clamped to the limit.
    assign integ_sum = {{4{integ_reg[0][23]}}, integ_reg[0]} + rnd24[27:0];
    assign lim_pos   = {5'd0, regs.integral_limit};
    assign lim_neg   = -lim_pos;

    always_comb
    begin
        if (integ_sum > lim_pos)
        begin
            integ_new = lim_pos[23:0];
        end
        else if (integ_sum < lim_neg)
        begin
            integ_new = lim_neg[23:0];
        end
        else
        begin
            integ_new = integ_sum[23:0];
        end
    end

    // Raw derivative saturated to 40 bits.
    always_comb
    begin
        if (r8_43 > MAX40_43)
        begin
            deriv_new = MAX40_43[39:0];
        end
        else if (r8_43 < MIN40_43)
        begin
            deriv_new = MIN40_43[39:0];
        end
        else
        begin
            deriv_new = r8_43[39:0];
        end
    end

    // Filter state update saturated to 40 bits.
    assign fd_sum = {{4{fd_reg[0][39]}}, fd_reg[0]} + {r16_43[42], r16_43};

    always_comb
    begin
        if (fd_sum > MAX40_44)
        begin
            fd_new = MAX40_44[39:0];
        end
        else if (fd_sum < MIN40_44)
        begin
            fd_new = MIN40_44[39:0];
        end
        else
        begin
            fd_new = fd_sum[39:0];
        end
    end

    // Torque saturated to 24 bits.
    always_comb
    begin
        if (r16_43 > MAX24_43)
        begin
            tq_new = MAX24_43[23:0];
        end
        else if (r16_43 < MIN24_43)
        begin
            tq_new = MIN24_43[23:0];
        end
        else
        begin
            tq_new = r16_43[23:0];
        end
    end

    // Sequencer, writebacks and output register.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        inc1_next      = inc1_reg;
        d_next         = d_reg;
        sp_next        = sp_reg;
        meas_next      = meas_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        fd_next        = fd_reg;
        work_next      = work_reg;
        out_next       = out_reg;

        if (torques.valid && torques.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    for (int k = 0; k < AXES; k++)
                    begin
                        sp_next[k]   = in_sp[k];
                        meas_next[k] = in_meas[k];
                    end
                    step_next  = '0;
                    axis_next  = '0;
                    state_next = ST_RUN;
                end
            end

            ST_RUN:
            begin
                case (step.wb)
                    WB_LOAD:
                    begin
                        err_next  = {sp_reg[0][23], sp_reg[0]} - {meas_reg[0][23], meas_reg[0]};
                        diff_next = {meas_reg[0][23], meas_reg[0]} - {prev_reg[0][23], prev_reg[0]};
                    end
                    WB_INC1:
                    begin
                        inc1_next = rnd16[25:0];
                    end
                    WB_INTEG:
                    begin
                        integ_next[0] = integ_new;
                    end
                    WB_DERIV:
                    begin
                        d_next = {deriv_new[39], deriv_new} - {fd_reg[0][39], fd_reg[0]};
                    end
                    WB_FD:
                    begin
                        fd_next[0] = fd_new;
                    end
                    WB_TORQUE:
                    begin
                        // Shift the torque in and rotate to the next axis.
                        for (int k = 0; k < AXES - 1; k++)
                        begin
                            work_next[k]  = work_reg[k+1];
                            sp_next[k]    = sp_reg[k+1];
                            meas_next[k]  = meas_reg[k+1];
                            integ_next[k] = integ_reg[k+1];
                            prev_next[k]  = prev_reg[k+1];
                            fd_next[k]    = fd_reg[k+1];
                        end
                        work_next[AXES-1]  = tq_new;
                        sp_next[AXES-1]    = sp_reg[0];
                        meas_next[AXES-1]  = meas_reg[0];
                        integ_next[AXES-1] = integ_reg[0];
                        prev_next[AXES-1]  = meas_reg[0];
                        fd_next[AXES-1]    = fd_reg[0];
                    end
                    default:
                    begin
                        err_next = err_reg;
                    end
                endcase

                if (step_reg == LAST_STEP)
                begin
                    step_next = '0;
                    if (axis_reg == LAST_AXIS)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || torques.ready)
                begin
                    out_next       = final_tq;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and per-axis state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < AXES; k++)
            begin
                integ_reg[k] <= '0;
                prev_reg[k]  <= '0;
                fd_reg[k]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            fd_reg        <= fd_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        diff_reg <= diff_next;
        inc1_reg <= inc1_next;
        d_reg    <= d_next;
        sp_reg   <= sp_next;
        meas_reg <= meas_next;
        work_reg <= work_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

FILE: src/trpid_regs.sv
`default_nettype none

module trpid_regs (
    input  wire logic       clk,
    input  wire logic       rst_n,
    trpid_cfg_if.sink       cfg,
    output trpid_pkg::cfg_t regs
);
    import trpid_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode one register write per transfer.
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_P_GAINS:           regs_next.p_gains           = cfg.data;
                REG_I_GAINS:           regs_next.i_gains           = cfg.data;
                REG_D_GAINS:           regs_next.d_gains           = cfg.data;
                REG_FF_GAINS:          regs_next.ff_gains          = cfg.data;
                REG_INTEGRAL_LIMIT:    regs_next.integral_limit    = cfg.data[22:0];
                REG_STEP_TIME:         regs_next.step_time         = cfg.data[23:0];
                REG_INVERSE_STEP_TIME: regs_next.inverse_step_time = cfg.data[23:0];
                REG_FILTER_ALPHA:      regs_next.filter_alpha      = cfg.data[15:0];
                default:               regs_next = regs_reg;
            endcase
        end
    end

    // Register file with its power-on defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.p_gains           <= 48'd70369388406374;
            regs_reg.i_gains           <= 48'd56294351113421;
            regs_reg.d_gains           <= 48'd21496136;
            regs_reg.ff_gains          <= 48'd0;
            regs_reg.integral_limit    <= 23'd32768;
            regs_reg.step_time         <= 24'd16777;
            regs_reg.inverse_step_time <= 24'd256000;
            regs_reg.filter_alpha      <= 16'd21928;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/trpid_mac.sv
`default_nettype none

module trpid_mac (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire trpid_pkg::mac_ctl_t                 ctl,
    input  wire logic signed [trpid_pkg::OPA_W-1:0]  op_a,
    input  wire logic signed [trpid_pkg::OPB_W-1:0]  op_b,
    output logic signed [trpid_pkg::ACC_W-1:0]       acc
);
    import trpid_pkg::*;

    mac_ctl_t                 ctl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  addend;

    assign acc = acc_reg;

    // Multiplier stage.
    assign prod_next = op_a * op_b;

    // Accumulate stage: the product is added unshifted or weighted by 2^24.
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign addend   = ctl_reg.sh24 ? (prod_ext <<< 24) : prod_ext;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl_reg.en)
        begin
            acc_next = (ctl_reg.clr ? '0 : acc_reg) + addend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

`default_nettype wire

FILE: bench/tb_three_axis_rate_pid_core.sv
`timescale 1ns / 100ps

import trpid_pkg::*;

typedef logic signed [DATA_W-1:0] rate_t;

// One sample transfer; index 0 is roll, 1 pitch, 2 yaw.
typedef struct packed {
    rate_t [2:0] setpoint;
    rate_t [2:0] measured;
} rate_sample_t;

// One torque transfer, same axis order.
typedef struct packed {
    rate_t [2:0] torque;
} torque_set_t;

localparam longint TORQUE_MAX = 64'sd8388607;
localparam longint TORQUE_MIN = -64'sd8388608;
localparam longint DERIV_MAX  = 64'sd549755813887;
localparam longint DERIV_MIN  = -64'sd549755813888;

// Tracks the controller state and the torques that are still owed.
class torque_scoreboard;
    logic [PACK_W-1:0] p_gains;
    logic [PACK_W-1:0] i_gains;
    logic [PACK_W-1:0] d_gains;
    logic [PACK_W-1:0] ff_gains;
    longint            integral_limit;
    longint            step_time;
    longint            inverse_step_time;
    longint            filter_alpha;
    longint            integ[3];
    longint            prev_rate[3];
    longint            filt_deriv[3];
    torque_set_t       expected_torques[$];
    int                mismatches;

    function new();
        int a;
        p_gains           = 48'd70369388406374;
        i_gains           = 48'd56294351113421;
        d_gains           = 48'd21496136;
        ff_gains          = '0;
        integral_limit    = 32768;
        step_time         = 16777;
        inverse_step_time = 256000;
        filter_alpha      = 21928;
        for (a = 0; a < 3; a++)
        begin
            integ[a]      = 0;
            prev_rate[a]  = 0;
            filt_deriv[a] = 0;
        end
        mismatches = 0;
    endfunction

    // Divide by 2^n, rounding to nearest with ties toward +infinity.
    function longint round_shift(longint x, int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function longint axis_gain(logic [PACK_W-1:0] gains, int axis);
        return longint'(gains[GAIN_W*axis +: GAIN_W]);
    endfunction

    function int pending();
        return expected_torques.size();
    endfunction

    // Mirror a configuration transfer; unused indexes change nothing.
    function void write_register(logic [CFG_IDX_W-1:0] index, logic [PACK_W-1:0] value);
        case (index)
            REG_P_GAINS:           p_gains = value;
            REG_I_GAINS:           i_gains = value;
            REG_D_GAINS:           d_gains = value;
            REG_FF_GAINS:          ff_gains = value;
            REG_INTEGRAL_LIMIT:    integral_limit = longint'(value[22:0]);
            REG_STEP_TIME:         step_time = longint'(value[23:0]);
            REG_INVERSE_STEP_TIME: inverse_step_time = longint'(value[23:0]);
            REG_FILTER_ALPHA:      filter_alpha = longint'(value[15:0]);
            default:               ;
        endcase
    endfunction

    // Advance the per-axis state for one sample and queue its torques.
    function void note_sample(rate_sample_t s);
        torque_set_t t;
        longint      sp;
        longint      meas;
        longint      err;
        longint      inc;
        longint      deriv;
        longint      fd;
        longint      sum;
        int          a;
        for (a = 0; a < 3; a++)
        begin
            sp   = longint'($signed(s.setpoint[a]));
            meas = longint'($signed(s.measured[a]));
            err  = sp - meas;

            inc      = round_shift(axis_gain(i_gains, a) * err, 16);
            inc      = round_shift(inc * step_time, 24);
            integ[a] = clip(integ[a] + inc, -integral_limit, integral_limit);

            deriv = round_shift((meas - prev_rate[a]) * inverse_step_time, 8);
            deriv = clip(deriv, DERIV_MIN, DERIV_MAX);
            fd    = filt_deriv[a];
            fd    = fd + round_shift(filter_alpha * (deriv - fd), 16);
            filt_deriv[a] = clip(fd, DERIV_MIN, DERIV_MAX);
            prev_rate[a]  = meas;

            sum = axis_gain(p_gains, a) * err
                + integ[a] * 65536
                + axis_gain(d_gains, a) * filt_deriv[a]
                + axis_gain(ff_gains, a) * sp;
            t.torque[a] = rate_t'(clip(round_shift(sum, 16), TORQUE_MIN, TORQUE_MAX));
        end
        expected_torques.push_back(t);
    endfunction

    task report(string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Compare a torque transfer against the oldest owed result.
    task check_torque(torque_set_t got);
        torque_set_t want;
        int          a;
        if (expected_torques.size() == 0)
        begin
            report($sformatf("torque transfer with no sample pending: %0d %0d %0d",
                             got.torque[0], got.torque[1], got.torque[2]));
        end
        else
        begin
            want = expected_torques.pop_front();
            for (a = 0; a < 3; a++)
            begin
                if (got.torque[a] !== want.torque[a])
                    report($sformatf("torque axis %0d: got %0d, expected %0d",
                                     a, got.torque[a], want.torque[a]));
            end
        end
    endtask
endclass

module tb_three_axis_rate_pid_core;

    localparam int    LIMIT_CYCLES = 400000;
    localparam int    IDLE_MARGIN  = 80;
    localparam int    DRIFT_MAX    = 1 << 20;
    localparam rate_t RATE_MAX     = 24'sh7FFFFF;
    localparam rate_t RATE_MIN     = -24'sh800000;

    // Indexes past the last register, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_FILTER_ALPHA + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    logic clk = 1'b0;
    logic rst_n;

    int idle_pct;
    int stall_pct;
    int drift[3];
    int cycles;

    torque_scoreboard sb;

    trpid_in_if  samples_if ();
    trpid_out_if torques_if ();
    trpid_cfg_if cfg_if ();

    three_axis_rate_pid_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .torques (torques_if),
        .cfg     (cfg_if)
    );

    always #2 clk = ~clk;

    // Torque receiver: stalls at random per the current stall rate.
    initial
    begin
        torques_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            torques_if.ready <= (int'($urandom_range(99)) >= stall_pct);
        end
    end

    // Watch every transfer on the three channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                sb.write_register(cfg_if.index, cfg_if.data);
            if (samples_if.valid && samples_if.ready)
                sb.note_sample({samples_if.setpoint_yaw, samples_if.setpoint_pitch,
                                samples_if.setpoint_roll, samples_if.measured_yaw,
                                samples_if.measured_pitch, samples_if.measured_roll});
            if (torques_if.valid && torques_if.ready)
                sb.check_torque({torques_if.torque_yaw, torques_if.torque_pitch,
                                 torques_if.torque_roll});
        end
    end

    // Run limit.
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Present one sample after a random gap and hold it until its transfer.
    task automatic send_sample(input rate_sample_t s);
        @(negedge clk);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(negedge clk);
        end
        samples_if.valid          <= 1'b1;
        samples_if.setpoint_roll  <= s.setpoint[0];
        samples_if.setpoint_pitch <= s.setpoint[1];
        samples_if.setpoint_yaw   <= s.setpoint[2];
        samples_if.measured_roll  <= s.measured[0];
        samples_if.measured_pitch <= s.measured[1];
        samples_if.measured_yaw   <= s.measured[2];
        do
            @(posedge clk);
        while (!samples_if.ready);
    endtask

    // Stop sending and wait until every owed torque has come out.
    task automatic wait_idle();
        @(negedge clk);
        samples_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (IDLE_MARGIN) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [PACK_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic rate_sample_t uniform(input rate_t sp, input rate_t meas);
        rate_sample_t s;
        int           a;
        for (a = 0; a < 3; a++)
        begin
            s.setpoint[a] = sp;
            s.measured[a] = meas;
        end
        return s;
    endfunction

    // Mostly slowly drifting rates with moderate error, some full-range noise.
    function automatic rate_sample_t random_sample();
        rate_sample_t s;
        int           a;
        int           offset;
        for (a = 0; a < 3; a++)
        begin
            if ($urandom_range(9) < 3)
            begin
                s.setpoint[a] = rate_t'($urandom());
                s.measured[a] = rate_t'($urandom());
            end
            else
            begin
                drift[a] = drift[a] + int'($urandom_range(8192)) - 4096;
                if (drift[a] > DRIFT_MAX)
                    drift[a] = DRIFT_MAX;
                if (drift[a] < -DRIFT_MAX)
                    drift[a] = -DRIFT_MAX;
                offset        = int'($urandom_range(65536)) - 32768;
                s.measured[a] = rate_t'(drift[a]);
                s.setpoint[a] = rate_t'(drift[a] + offset);
            end
        end
        return s;
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(3))
            0:       return GAIN_W'($urandom_range(1023));
            1:       return GAIN_W'($urandom_range(8191));
            2:       return GAIN_W'($urandom());
            default: return '1;
        endcase
    endfunction

    task automatic random_config();
        write_reg(REG_P_GAINS, {random_gain(), random_gain(), random_gain()});
        write_reg(REG_I_GAINS, {random_gain(), random_gain(), random_gain()});
        write_reg(REG_D_GAINS, {random_gain(), random_gain(), random_gain()});
        write_reg(REG_FF_GAINS, {random_gain(), random_gain(), random_gain()});
        write_reg(REG_INTEGRAL_LIMIT, PACK_W'($urandom_range(24'h7FFFFF)));
        if ($urandom_range(1) == 0)
            write_reg(REG_STEP_TIME, PACK_W'($urandom_range(24'hFFFFFF, 1)));
        else
            write_reg(REG_STEP_TIME, PACK_W'($urandom_range(24'h1FFFF, 1)));
        if ($urandom_range(1) == 0)
            write_reg(REG_INVERSE_STEP_TIME, PACK_W'($urandom_range(24'hFFFFFF, 1)));
        else
            write_reg(REG_INVERSE_STEP_TIME, PACK_W'($urandom_range(24'h7FFFF, 1)));
        write_reg(REG_FILTER_ALPHA, PACK_W'($urandom_range(16'hFFFF)));
    endtask

    initial
    begin
        int seg;
        int n;

        rst_n                     = 1'b0;
        samples_if.valid          = 1'b0;
        samples_if.setpoint_roll  = '0;
        samples_if.setpoint_pitch = '0;
        samples_if.setpoint_yaw   = '0;
        samples_if.measured_roll  = '0;
        samples_if.measured_pitch = '0;
        samples_if.measured_yaw   = '0;
        cfg_if.valid              = 1'b0;
        cfg_if.index              = '0;
        cfg_if.data               = '0;
        idle_pct                  = 0;
        stall_pct                 = 0;
        for (n = 0; n < 3; n++)
            drift[n] = 0;
        sb = new();

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: zero, full-scale error both ways, both rails.
        send_sample(uniform('0, '0));
        send_sample(uniform(RATE_MAX, RATE_MIN));
        send_sample(uniform(RATE_MIN, RATE_MAX));
        send_sample(uniform(RATE_MAX, RATE_MAX));
        send_sample(uniform(RATE_MIN, RATE_MIN));
        send_sample(random_sample());

        // Every register at its top value.
        wait_idle();
        write_reg(REG_P_GAINS, '1);
        write_reg(REG_I_GAINS, '1);
        write_reg(REG_D_GAINS, '1);
        write_reg(REG_FF_GAINS, '1);
        write_reg(REG_INTEGRAL_LIMIT, PACK_W'(23'h7FFFFF));
        write_reg(REG_STEP_TIME, PACK_W'(24'hFFFFFF));
        write_reg(REG_INVERSE_STEP_TIME, PACK_W'(24'hFFFFFF));
        write_reg(REG_FILTER_ALPHA, PACK_W'(16'hFFFF));
        send_sample(uniform(RATE_MAX, RATE_MIN));
        send_sample(uniform(RATE_MIN, RATE_MAX));
        send_sample(uniform(RATE_MIN, RATE_MIN));
        send_sample(random_sample());

        // Zero step time holds the integrator; zero inverse step time kills
        // the derivative input so the filter decays.
        wait_idle();
        write_reg(REG_STEP_TIME, '0);
        write_reg(REG_INVERSE_STEP_TIME, '0);
        send_sample(uniform(RATE_MAX, RATE_MIN));
        send_sample(uniform(RATE_MIN, '0));

        // Zero P and feed-forward gains and a frozen filter.
        wait_idle();
        write_reg(REG_FILTER_ALPHA, '0);
        write_reg(REG_P_GAINS, '0);
        write_reg(REG_FF_GAINS, '0);
        write_reg(REG_INVERSE_STEP_TIME, PACK_W'(24'd1));
        send_sample(uniform(RATE_MAX, RATE_MIN));

        // Wind the integrator up, then lower the limit under it.
        wait_idle();
        write_reg(REG_STEP_TIME, PACK_W'(24'hFFFFFF));
        write_reg(REG_INTEGRAL_LIMIT, PACK_W'(23'h7FFFFF));
        write_reg(REG_P_GAINS, PACK_W'(48'h0001_0001_0001));
        send_sample(uniform(RATE_MAX, RATE_MIN));
        wait_idle();
        write_reg(REG_INTEGRAL_LIMIT, PACK_W'(23'h000100));
        send_sample(uniform('0, '0));
        wait_idle();
        write_reg(REG_INTEGRAL_LIMIT, '0);
        send_sample(uniform(RATE_MIN, RATE_MAX));

        // Writes to unused indexes must leave the configuration alone.
        wait_idle();
        write_reg(REG_FIRST_UNUSED, '1);
        write_reg(REG_LAST_UNUSED, '1);
        send_sample(uniform(RATE_MAX, RATE_MIN));
        send_sample(random_sample());

        // Random segments, each with a fresh configuration and idle pattern.
        for (seg = 0; seg < 8; seg++)
        begin
            wait_idle();
            case (seg % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 74; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            random_config();
            for (n = 0; n < 56; n++)
            begin
                // Now and then hold off until the pipeline is empty.
                if ($urandom_range(39) == 0 || (seg == 1 && n == 20))
                    wait_idle();
                send_sample(random_sample());
            end
        end

        wait_idle();
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
